// ----- hw/rtl/zvfe_pkg.sv -----
// Shared constants and types for the zigzag varint field encoder.
package zvfe_pkg;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] KEY_MORE   = 8'h80;
  localparam logic [7:0] KEY_INT    = 8'h01;
  localparam logic [7:0] KEY_LONG   = 8'h02;
  localparam logic [7:0] CONT_BIT   = 8'h80;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified field waiting for the serializer.
  typedef struct packed {
    logic        start;
    logic [7:0]  key;
    logic [63:0] zz;
  } zvfe_entry_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_KEY   = 4'b0100,
    S_DATA  = 4'b1000
  } zvfe_state_t;

endpackage

// ----- hw/rtl/zvfe_if.sv -----
// Handshake channels: record fields in, encoded bytes out.
interface zvfe_field_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] field_value;
  logic               field_is_long;
  logic               last_field;

  modport source (output valid, field_value, field_is_long, last_field, input ready);
  modport sink (input valid, field_value, field_is_long, last_field, output ready);
endinterface

interface zvfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

// ----- hw/rtl/zvfe_front.sv -----
// Front end: accepts fields, zigzag-codes them and builds start flag and key.
module zvfe_front (
  input  logic                 clk,
  input  logic                 rst,
  zvfe_field_if.sink           field,
  input  logic                 q_ready,
  output logic                 q_push,
  output zvfe_pkg::zvfe_entry_t q_data
);

  logic        at_record_start;
  logic [31:0] low;
  logic [63:0] zz_int;
  logic [63:0] zz_long;
  logic [7:0]  key_kind;

  assign field.ready = q_ready;
  assign q_push      = field.valid && q_ready;

  assign low     = field.field_value[31:0];
  assign zz_int  = {32'd0, {low[30:0], 1'b0} ^ {32{low[31]}}};
  assign zz_long = {field.field_value[62:0], 1'b0} ^ {64{field.field_value[63]}};

  assign key_kind = field.field_is_long ? zvfe_pkg::KEY_LONG : zvfe_pkg::KEY_INT;

  always_comb begin
    q_data.start = at_record_start;
    q_data.key   = key_kind | (field.last_field ? 8'h00 : zvfe_pkg::KEY_MORE);
    q_data.zz    = field.field_is_long ? zz_long : zz_int;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_record_start <= 1'b1;
    end else if (q_push) begin
      at_record_start <= field.last_field;
    end
  end

endmodule

// ----- hw/rtl/zvfe_queue.sv -----
// Short queue of classified fields between front end and serializer.
module zvfe_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  zvfe_pkg::zvfe_entry_t push_data,
  output logic                  push_ready,
  input  logic                  pop,
  output logic                  pop_valid,
  output zvfe_pkg::zvfe_entry_t pop_data
);

  zvfe_pkg::zvfe_entry_t                 mem [zvfe_pkg::QUEUE_DEPTH];
  logic [zvfe_pkg::QPTR_W-1:0]           wptr;
  logic [zvfe_pkg::QPTR_W-1:0]           rptr;
  logic [zvfe_pkg::QCNT_W-1:0]           count;
  logic                                  do_push;
  logic                                  do_pop;

  assign push_ready = (count != zvfe_pkg::QCNT_W'(zvfe_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == zvfe_pkg::QPTR_W'(zvfe_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == zvfe_pkg::QPTR_W'(zvfe_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= zvfe_pkg::QCNT_W'(zvfe_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_full_blocks_push: assert property (@(posedge clk) disable iff (rst)
    (count == zvfe_pkg::QCNT_W'(zvfe_pkg::QUEUE_DEPTH) && !do_pop) |=> $stable(count))
    else $error("queue count changed while full without a pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == zvfe_pkg::QCNT_W'(zvfe_pkg::QUEUE_DEPTH)) |-> (wptr == rptr))
    else $error("queue pointers disagree with count");

endmodule

// ----- hw/rtl/zvfe_back.sv -----
// Serializer: emits start byte, key byte and varint bytes, one per beat.
module zvfe_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  zvfe_pkg::zvfe_entry_t q_data,
  output logic                  q_pop,
  zvfe_byte_if.source           stream
);

  zvfe_pkg::zvfe_state_t state;
  zvfe_pkg::zvfe_state_t state_next;
  logic [7:0]            key;
  logic [63:0]           rest;
  logic                  more;
  logic                  fire;
  logic                  load;

  assign more = (rest[63:7] != '0);
  assign fire = stream.valid && stream.ready;
  // A new field loads when idle or right as the final byte of the previous one leaves.
  assign load = q_valid && ((state == zvfe_pkg::S_IDLE) ||
                            (state == zvfe_pkg::S_DATA && fire && !more));
  assign q_pop = load;

  assign stream.valid = (state != zvfe_pkg::S_IDLE);

  always_comb begin
    stream.out_byte  = 8'h00;
    stream.last_byte = 1'b0;
    unique case (state)
      zvfe_pkg::S_IDLE:  stream.out_byte = 8'h00;
      zvfe_pkg::S_START: stream.out_byte = zvfe_pkg::START_BYTE;
      zvfe_pkg::S_KEY:   stream.out_byte = key;
      zvfe_pkg::S_DATA: begin
        stream.out_byte  = {1'b0, rest[6:0]} | (more ? zvfe_pkg::CONT_BIT : 8'h00);
        stream.last_byte = !more;
      end
      default:           stream.out_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_next = state;
    if (load) begin
      state_next = q_data.start ? zvfe_pkg::S_START : zvfe_pkg::S_KEY;
    end else begin
      unique case (state)
        zvfe_pkg::S_IDLE:  state_next = zvfe_pkg::S_IDLE;
        zvfe_pkg::S_START: if (fire) state_next = zvfe_pkg::S_KEY;
        zvfe_pkg::S_KEY:   if (fire) state_next = zvfe_pkg::S_DATA;
        zvfe_pkg::S_DATA:  if (fire && !more) state_next = zvfe_pkg::S_IDLE;
        default:           state_next = zvfe_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zvfe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key  <= q_data.key;
      rest <= q_data.zz;
    end else if (state == zvfe_pkg::S_DATA && fire && more) begin
      rest <= {7'd0, rest[63:7]};
    end
  end

  a_start_then_key: assert property (@(posedge clk) disable iff (rst)
    (state == zvfe_pkg::S_START && fire) |=> (state == zvfe_pkg::S_KEY))
    else $error("start byte not followed by key byte");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    (state == zvfe_pkg::S_DATA && fire && more) |=>
      (state == zvfe_pkg::S_DATA && rest == {7'd0, $past(rest[63:7])}))
    else $error("varint continuation lost");

  a_key_kind: assert property (@(posedge clk) disable iff (rst)
    (state == zvfe_pkg::S_KEY) |-> (key[6:0] == 7'h01 || key[6:0] == 7'h02))
    else $error("key byte carries no valid kind");

  a_pop_only_at_boundary: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == zvfe_pkg::S_IDLE || (state == zvfe_pkg::S_DATA && stream.last_byte)))
    else $error("queue popped in the middle of a field");

endmodule

// ----- hw/rtl/zigzag_varint_field_encoder.sv -----
// Top level of the zigzag varint field encoder.
// Each accepted field produces one byte per cycle on the stream channel, while the channel is
// ready: a 0xFF start byte when the field opens a record, a key byte (0x80 for more fields,
// ORed with 0x01 for int or 0x02 for long), then the zigzag value as a varint, low seven bits
// first, with last_byte set on the final varint byte. A field therefore produces 2 to 12 output
// bytes, which leave one at a time over the serializer's single byte lane. The front end classifies fields and
// parks up to two of them in a queue, so the field channel keeps accepting while bytes of an
// earlier field are still going out, and consecutive fields stream without idle cycles.
module zigzag_varint_field_encoder (
  input  logic        clk,
  input  logic        rst,
  zvfe_field_if.sink  field,
  zvfe_byte_if.source stream
);

  logic                  q_push;
  logic                  q_ready;
  zvfe_pkg::zvfe_entry_t q_in;
  logic                  q_pop;
  logic                  q_valid;
  zvfe_pkg::zvfe_entry_t q_out;

  zvfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .field   (field),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  zvfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  zvfe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .stream  (stream)
  );

endmodule

// ----- dv/tb_zigzag_varint_field_encoder.sv -----
// Self-checking testbench for the zigzag varint field encoder: directed table plus random fields.
module tb_zigzag_varint_field_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 400;
  localparam int TAIL_CYCLES = 24;
  localparam int RANDOM_FIELDS = 440;
  localparam int CALM_FIELDS = 60;

  // One row of the directed table. Byte counts of zero mean the encoding is predicted.
  typedef struct packed {
    logic [63:0] value;
    logic        is_long;
    logic        ends_rec;
    logic [3:0]  n_bytes;
    logic [95:0] bytes_hex;
  } field_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst;

  zvfe_field_if field_ch ();
  zvfe_byte_if  byte_ch ();

  zigzag_varint_field_encoder DUT (
    .clk    (clk),
    .rst    (rst),
    .field  (field_ch.sink),
    .stream (byte_ch.source)
  );

  always #6 clk = ~clk;

  stream_byte_t stream_due[$];
  field_row_t   dir_rows[$];
  logic         rec_open_next;
  int           errors;
  int           n_fields;
  int           n_long;
  int           n_records;
  int           n_bytes_seen;
  int           n_widest;
  bit           calm;
  int           tx_odds;
  int           rx_odds;

  // Expected encoding of one field; the first byte ends up in the most significant slot.
  function automatic int encode_field(input logic [63:0] v, input logic lng, input logic lst,
                                      output logic [95:0] seq);
    logic [63:0] zz;
    logic [31:0] lo;
    int          n;
    n = 0;
    seq = '0;
    if (rec_open_next) begin
      seq = {seq[87:0], zvfe_pkg::START_BYTE};
      n++;
    end
    seq = {seq[87:0], (lng ? zvfe_pkg::KEY_LONG : zvfe_pkg::KEY_INT) |
                      (lst ? 8'h00 : zvfe_pkg::KEY_MORE)};
    n++;
    if (lng) begin
      zz = {v[62:0], 1'b0} ^ {64{v[63]}};
    end else begin
      lo = v[31:0];
      zz = {32'h0, {lo[30:0], 1'b0} ^ {32{lo[31]}}};
    end
    do begin
      seq = {seq[87:0], (zz > 64'h7F ? zvfe_pkg::CONT_BIT : 8'h00) | {1'b0, zz[6:0]}};
      n++;
      zz = zz >> 7;
    end while (zz != 64'h0);
    rec_open_next = lst;
    return n;
  endfunction

  task automatic add_row(input logic [63:0] v, input logic lng, input logic lst,
                         input int n, input logic [95:0] seq);
    field_row_t r;
    r.value = v;
    r.is_long = lng;
    r.ends_rec = lst;
    r.n_bytes = n[3:0];
    r.bytes_hex = seq;
    dir_rows.push_back(r);
  endtask

  // Called at a rising edge; returns at the edge where the field beat is taken.
  task automatic send_field(input logic [63:0] v, input logic lng, input logic lst,
                            input int n_typed, input logic [95:0] seq_typed);
    logic [95:0]  seq;
    int           n;
    stream_byte_t sb;
    n = encode_field(v, lng, lst, seq);
    if (n_typed != 0) begin
      n = n_typed;
      seq = seq_typed;
    end
    for (int i = 0; i < n; i++) begin
      sb.data = seq[8*(n-1-i) +: 8];
      sb.fin = (i == n - 1);
      stream_due.push_back(sb);
    end
    n_fields++;
    if (lng) n_long++;
    if (lst) n_records++;
    if (n == 12) n_widest++;
    field_ch.valid <= 1'b1;
    field_ch.field_value <= v;
    field_ch.field_is_long <= lng;
    field_ch.last_field <= lst;
    @(posedge clk);
    while (!field_ch.ready) @(posedge clk);
  endtask

  task automatic field_gap(input int cycles);
    field_ch.valid <= 1'b0;
    field_ch.field_value <= {$urandom, $urandom};
    field_ch.field_is_long <= 1'($urandom_range(1));
    field_ch.last_field <= 1'($urandom_range(1));
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the field channel off until every predicted byte has come out.
  task automatic drain_stream();
    field_ch.valid <= 1'b0;
    do @(posedge clk); while (stream_due.size() != 0);
  endtask

  task automatic maybe_gap();
    if (!calm && tx_odds != 0 && $urandom_range(tx_odds - 1) == 0)
      field_gap($urandom_range(6, 1));
  endtask

  task automatic random_field();
    logic [63:0] mag;
    logic [63:0] v;
    logic        lng;
    logic        lst;
    int          k;
    lng = 1'($urandom_range(1));
    lst = ($urandom_range(3) == 0);
    if ($urandom_range(19) == 0) begin
      case ($urandom_range(6))
        0: v = 64'h8000_0000_0000_0000;
        1: v = 64'h7FFF_FFFF_FFFF_FFFF;
        2: v = 64'h0;
        3: v = 64'hFFFF_FFFF_FFFF_FFFF;
        4: v = 64'h0000_0000_7FFF_FFFF;
        5: v = 64'hFFFF_FFFF_8000_0000;
        default: v = 64'h0000_0000_8000_0000;
      endcase
    end else begin
      // Random bit length keeps the varint lengths spread evenly.
      k = $urandom_range(64);
      mag = {$urandom, $urandom};
      mag = (k == 0) ? 64'h0 : mag >> (64 - k);
      v = $urandom_range(1) ? ~mag : mag;
    end
    if (!lng && $urandom_range(1)) v[63:32] = $urandom;
    send_field(v, lng, lst, 0, '0);
  endtask

  // Stream sink: ready drops in random bursts.
  initial begin
    int hold_left;
    hold_left = 0;
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        byte_ch.ready <= 1'b0;
      end else if (!calm && rx_odds != 0 && $urandom_range(rx_odds - 1) == 0) begin
        hold_left = $urandom_range(6, 1) - 1;
        byte_ch.ready <= 1'b0;
      end else begin
        byte_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    stream_byte_t sb;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      n_bytes_seen++;
      if (stream_due.size() == 0) begin
        $error("unexpected stream beat: out_byte 0x%02h last_byte %0b",
               byte_ch.out_byte, byte_ch.last_byte);
        errors++;
      end else begin
        sb = stream_due.pop_front();
        if (byte_ch.out_byte !== sb.data) begin
          $error("out_byte: expected 0x%02h, actual 0x%02h", sb.data, byte_ch.out_byte);
          errors++;
        end
        if (byte_ch.last_byte !== sb.fin) begin
          $error("last_byte: expected %0b, actual %0b", sb.fin, byte_ch.last_byte);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles where neither channel moves a beat.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (field_ch.valid && field_ch.ready) || (byte_ch.valid && byte_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d bytes still due", quiet,
                 stream_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    n_fields = 0;
    n_long = 0;
    n_records = 0;
    n_bytes_seen = 0;
    n_widest = 0;
    calm = 1'b0;
    tx_odds = 4;
    rx_odds = 4;
    rec_open_next = 1'b1;
    rst <= 1'b1;
    field_ch.valid <= 1'b0;
    field_ch.field_value <= 64'h0;
    field_ch.field_is_long <= 1'b0;
    field_ch.last_field <= 1'b0;

    // Typed rows: reset state, extremes, single-field records, ignored upper half.
    add_row(64'h0, 1'b0, 1'b0, 3, 96'hFF_81_00);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 2, 96'h81_01);
    add_row(64'h1, 1'b0, 1'b0, 2, 96'h81_02);
    add_row(64'h0000_0000_7FFF_FFFF, 1'b0, 1'b1, 6, 96'h01_FE_FF_FF_FF_0F);
    add_row(64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0, 7, 96'hFF_81_FF_FF_FF_FF_0F);
    add_row(64'h0, 1'b1, 1'b0, 2, 96'h82_00);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 11, 96'h82_FE_FF_FF_FF_FF_FF_FF_FF_FF_01);
    add_row(64'h8000_0000_0000_0000, 1'b1, 1'b1, 11, 96'h02_FF_FF_FF_FF_FF_FF_FF_FF_FF_01);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 3, 96'hFF_02_01);
    add_row(64'hDEAD_BEEF_0000_0005, 1'b0, 1'b0, 3, 96'hFF_81_0A);
    add_row(64'h1234_5678_FFFF_FFFF, 1'b0, 1'b0, 2, 96'h81_01);
    add_row(64'h0, 1'b0, 1'b1, 2, 96'h01_00);
    add_row(64'h0, 1'b0, 1'b1, 3, 96'hFF_01_00);
    // Predicted rows: varint length boundaries and int/long sign differences.
    add_row(64'h3F, 1'b0, 1'b0, 0, '0);
    add_row(64'h40, 1'b0, 1'b0, 0, '0);
    add_row(64'hFFFF_FFFF_FFFF_FFC0, 1'b1, 1'b0, 0, '0);
    add_row(64'hFFFF_FFFF_FFFF_FFBF, 1'b1, 1'b0, 0, '0);
    add_row(64'h0000_0000_8000_0000, 1'b1, 1'b0, 0, '0);
    add_row(64'h0000_0000_8000_0000, 1'b0, 1'b0, 0, '0);
    add_row(64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 0, '0);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 0, '0);
    add_row(64'h0102_0304_0506_0708, 1'b1, 1'b1, 0, '0);
    add_row(64'h1FFF, 1'b1, 1'b0, 0, '0);
    add_row(64'hFFFF_FFFF_FFFF_E000, 1'b0, 1'b1, 0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      maybe_gap();
      send_field(dir_rows[i].value, dir_rows[i].is_long, dir_rows[i].ends_rec,
                 dir_rows[i].n_bytes, dir_rows[i].bytes_hex);
    end
    drain_stream();

    for (int i = 0; i < RANDOM_FIELDS; i++) begin
      if (i % 40 == 0) begin
        // Choose at random between no idling, light idling and heavy idling.
        case ($urandom_range(2))
          0: begin tx_odds = 0; rx_odds = 0; end
          1: begin tx_odds = 8; rx_odds = 8; end
          default: begin tx_odds = 3; rx_odds = 3; end
        endcase
      end
      if (i > 0 && i % 120 == 0) drain_stream();
      if (i == RANDOM_FIELDS - CALM_FIELDS) calm = 1'b1;
      maybe_gap();
      random_field();
    end

    field_ch.valid <= 1'b0;
    do @(posedge clk); while (stream_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (stream_due.size() != 0) begin
      $error("%0d stream bytes never arrived", stream_due.size());
      errors++;
    end

    $display("Encoded %0d fields (%0d long, %0d closed records, %0d twelve-byte), %0d bytes.",
             n_fields, n_long, n_records, n_widest, n_bytes_seen);
    $display("Stimulus mixed int/long extremes, junk upper halves and random idling on both ends.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
